// File: design/rarmt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rarmt_pkg
// Shared widths, sequencer step codes and the status bundle of the range-add
// range-max tree.
// ----------------------------------------------------------------------------
package rarmt_pkg;

  localparam int LEAVES_DEFAULT = 1024;
  localparam int IDX_W          = 10;
  localparam int VAL_W          = 48;
  localparam int OUT_W          = 47;

  // Sequencer step codes, shared by the controller and the datapath.
  localparam int OP_W = 5;
  typedef logic [OP_W-1:0] op_t;

  localparam op_t ST_CLEAR   = 5'd0;
  localparam op_t ST_IDLE    = 5'd1;
  localparam op_t ST_PD_CHK  = 5'd2;
  localparam op_t ST_PD_RP   = 5'd3;
  localparam op_t ST_PD_W0   = 5'd4;
  localparam op_t ST_PD_W1   = 5'd5;
  localparam op_t ST_PD_Z    = 5'd6;
  localparam op_t ST_RG_CHK  = 5'd7;
  localparam op_t ST_RG_L    = 5'd8;
  localparam op_t ST_RG_RCHK = 5'd9;
  localparam op_t ST_RG_R    = 5'd10;
  localparam op_t ST_RB_A    = 5'd11;
  localparam op_t ST_RB_B    = 5'd12;
  localparam op_t ST_RB_C    = 5'd13;
  localparam op_t ST_OUT     = 5'd14;
  localparam op_t OP_LOAD    = 5'd15;
  localparam op_t OP_OUT     = 5'd16;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic h_zero;
    logic p_skip;
    logic side;
    logic pend_zero;
    logic l_le_r;
    logic l_odd;
    logic r_odd;
    logic i_zero;
    logic is_query;
    logic clr_last;
  } status_t;

endpackage

// File: design/rarmt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rarmt_ctrl
// Sequencer for the tree: clearing sweep, push-down, range walk, rebuild and
// result hand-off.
// ----------------------------------------------------------------------------
module rarmt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  rarmt_pkg::status_t st,
  output rarmt_pkg::op_t   op
);
  import rarmt_pkg::*;

  op_t  state;
  op_t  state_next;
  logic out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  // Step issued to the datapath this cycle.
  always_comb begin
    op = state;
    if (state == ST_IDLE) begin
      op = in_valid ? OP_LOAD : ST_IDLE;
    end else if (state == ST_OUT) begin
      op = out_free ? OP_OUT : ST_IDLE;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:   if (st.clr_last) state_next = ST_IDLE;
      ST_IDLE:    if (in_valid) state_next = ST_PD_CHK;
      ST_PD_CHK: begin
        if (st.h_zero) begin
          if (st.side) state_next = ST_RG_CHK;
        end else if (!st.p_skip) begin
          state_next = ST_PD_RP;
        end
      end
      ST_PD_RP:   state_next = st.pend_zero ? ST_PD_CHK : ST_PD_W0;
      ST_PD_W0:   state_next = ST_PD_W1;
      ST_PD_W1:   state_next = ST_PD_Z;
      ST_PD_Z:    state_next = ST_PD_CHK;
      ST_RG_CHK: begin
        if (!st.l_le_r) state_next = st.is_query ? ST_OUT : ST_RB_A;
        else if (st.l_odd) state_next = ST_RG_L;
        else if (!st.r_odd) state_next = ST_RG_R;
      end
      ST_RG_L:    state_next = ST_RG_RCHK;
      ST_RG_RCHK: state_next = st.r_odd ? ST_RG_CHK : ST_RG_R;
      ST_RG_R:    state_next = ST_RG_CHK;
      ST_RB_A: begin
        if (!st.i_zero) state_next = ST_RB_B;
        else if (st.side) state_next = ST_IDLE;
      end
      ST_RB_B:    state_next = ST_RB_C;
      ST_RB_C:    state_next = ST_RB_A;
      ST_OUT:     if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_CLEAR;
    endcase
  end

  // State and result valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (op == OP_OUT) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

// File: design/rarmt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rarmt_datapath
// Node-maximum and pending-add memories with the index, level and result
// registers that the sequencer steps through.
// ----------------------------------------------------------------------------
module rarmt_datapath #(
  parameter int LEAVES = rarmt_pkg::LEAVES_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rarmt_pkg::op_t                op,
  input  logic                          cmd,
  input  logic [rarmt_pkg::IDX_W-1:0]   lo_index,
  input  logic [rarmt_pkg::IDX_W-1:0]   hi_index,
  input  logic signed [rarmt_pkg::VAL_W-1:0] add_value,
  output logic [rarmt_pkg::OUT_W-1:0]   max_value,
  output rarmt_pkg::status_t            st
);
  import rarmt_pkg::*;

  localparam int NW     = $clog2(2 * LEAVES);
  localparam int PW     = NW - 1;
  localparam int LW     = NW + 1;
  localparam int LEVELS = $clog2(LEAVES + 1) - 1;
  localparam int HW     = $clog2(LEVELS + 2);
  localparam logic [HW-1:0] H_INIT = HW'(LEVELS + 1);

  typedef logic [VAL_W-1:0] val_t;

  logic [VAL_W-1:0] node_mem [2*LEAVES];
  logic [VAL_W-1:0] pend_mem [LEAVES];

  logic          nm_we;
  logic [NW-1:0] nm_waddr;
  logic [NW-1:0] nm_raddr;
  val_t          nm_wdata;
  val_t          nm_rd;
  logic          pd_we;
  logic [PW-1:0] pd_waddr;
  logic [PW-1:0] pd_raddr;
  val_t          pd_wdata;
  val_t          pend_rd;

  logic [NW-1:0] cnt;
  logic          is_q;
  val_t          v;
  val_t          pv;
  val_t          a;
  val_t          best;
  logic [LW-1:0] l;
  logic [LW-1:0] r;
  logic [NW-1:0] l0;
  logic [NW-1:0] r0;
  logic [HW-1:0] h;
  logic          side;
  logic [PW-1:0] i;

  logic [NW-1:0] leaf;
  logic [NW-1:0] p;
  logic [NW-1:0] c0;
  logic [NW-1:0] c1;
  logic [NW-1:0] lo_sat;
  logic [NW-1:0] hi_sat;

  // Signed maximum, first operand kept on a tie.
  function automatic val_t bigger(input val_t x, input val_t y);
    bigger = ($signed(x) >= $signed(y)) ? x : y;
  endfunction

  // Path node at the current level and its two children.
  assign leaf = side ? r0 : l0;
  assign p    = leaf >> h;
  assign c0   = {p[NW-2:0], 1'b0};
  assign c1   = {p[NW-2:0], 1'b1};

  // Indices beyond the last leaf saturate.
  assign lo_sat = (32'(lo_index) > LEAVES - 1) ? NW'(LEAVES - 1) : NW'(lo_index);
  assign hi_sat = (32'(hi_index) > LEAVES - 1) ? NW'(LEAVES - 1) : NW'(hi_index);

  assign st.h_zero    = (h == '0);
  assign st.p_skip    = (p == '0) || (32'(p) >= LEAVES);
  assign st.side      = side;
  assign st.pend_zero = (pend_rd == '0);
  assign st.l_le_r    = (l <= r);
  assign st.l_odd     = l[0];
  assign st.r_odd     = r[0];
  assign st.i_zero    = (i == '0);
  assign st.is_query  = is_q;
  assign st.clr_last  = (cnt == NW'(2 * LEAVES - 1));

  // Memory port control for each step.
  always_comb begin
    nm_we    = 1'b0;
    nm_waddr = NW'(l);
    nm_wdata = nm_rd + v;
    nm_raddr = NW'(l);
    pd_we    = 1'b0;
    pd_waddr = PW'(l);
    pd_wdata = pend_rd + v;
    pd_raddr = PW'(l);
    case (op)
      ST_CLEAR: begin
        nm_we    = 1'b1;
        nm_waddr = cnt;
        nm_wdata = '0;
        pd_we    = (32'(cnt) < LEAVES);
        pd_waddr = PW'(cnt);
        pd_wdata = '0;
      end
      ST_PD_CHK: pd_raddr = PW'(p);
      ST_PD_RP: begin
        nm_raddr = c0;
        pd_raddr = PW'(c0);
      end
      ST_PD_W0: begin
        nm_we    = 1'b1;
        nm_waddr = c0;
        nm_wdata = nm_rd + pv;
        pd_we    = (32'(c0) < LEAVES);
        pd_waddr = PW'(c0);
        pd_wdata = pend_rd + pv;
        nm_raddr = c1;
        pd_raddr = PW'(c1);
      end
      ST_PD_W1: begin
        nm_we    = 1'b1;
        nm_waddr = c1;
        nm_wdata = nm_rd + pv;
        pd_we    = (32'(c1) < LEAVES);
        pd_waddr = PW'(c1);
        pd_wdata = pend_rd + pv;
      end
      ST_PD_Z: begin
        pd_we    = 1'b1;
        pd_waddr = PW'(p);
        pd_wdata = '0;
      end
      ST_RG_CHK: begin
        nm_raddr = l[0] ? NW'(l) : NW'(r);
        pd_raddr = l[0] ? PW'(l) : PW'(r);
      end
      ST_RG_L: begin
        nm_we = !is_q;
        pd_we = !is_q && (32'(l) < LEAVES);
      end
      ST_RG_RCHK: begin
        nm_raddr = NW'(r);
        pd_raddr = PW'(r);
      end
      ST_RG_R: begin
        nm_we    = !is_q;
        nm_waddr = NW'(r);
        pd_we    = !is_q && (32'(r) < LEAVES);
        pd_waddr = PW'(r);
      end
      ST_RB_A: begin
        nm_raddr = {i, 1'b0};
        pd_raddr = i;
      end
      ST_RB_B: nm_raddr = {i, 1'b1};
      ST_RB_C: begin
        nm_we    = 1'b1;
        nm_waddr = {1'b0, i};
        nm_wdata = bigger(a, nm_rd) + pv;
      end
      default: ;
    endcase
  end

  // Tree memories with registered reads.
  always_ff @(posedge clk) begin
    if (nm_we) node_mem[nm_waddr] <= nm_wdata;
    nm_rd <= node_mem[nm_raddr];
  end

  always_ff @(posedge clk) begin
    if (pd_we) pend_mem[pd_waddr] <= pd_wdata;
    pend_rd <= pend_mem[pd_raddr];
  end

  // Sweep counter for the clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (op == ST_CLEAR) begin
      cnt <= cnt + NW'(1);
    end
  end

  // Working registers of one command.
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        is_q <= cmd;
        v    <= add_value;
        l    <= LW'(lo_sat) + LW'(LEAVES);
        r    <= LW'(hi_sat) + LW'(LEAVES);
        l0   <= NW'(LW'(lo_sat) + LW'(LEAVES));
        r0   <= NW'(LW'(hi_sat) + LW'(LEAVES));
        h    <= H_INIT;
        side <= 1'b0;
        best <= '0;
      end
      ST_PD_CHK: begin
        if (h == '0) begin
          side <= 1'b1;
          h    <= H_INIT;
        end else if (st.p_skip) begin
          h <= h - HW'(1);
        end
      end
      ST_PD_RP: begin
        pv <= pend_rd;
        if (pend_rd == '0) h <= h - HW'(1);
      end
      ST_PD_Z: h <= h - HW'(1);
      ST_RG_CHK: begin
        if (l > r) begin
          side <= 1'b0;
          i    <= l0[NW-1:1];
        end else if (!l[0] && r[0]) begin
          l <= l >> 1;
          r <= r >> 1;
        end
      end
      ST_RG_L: begin
        if (is_q) best <= bigger(best, nm_rd);
        l <= l + LW'(1);
      end
      ST_RG_RCHK: begin
        if (r[0]) begin
          l <= l >> 1;
          r <= r >> 1;
        end
      end
      ST_RG_R: begin
        if (is_q) best <= bigger(best, nm_rd);
        l <= l >> 1;
        r <= (r - LW'(1)) >> 1;
      end
      ST_RB_A: begin
        if ((i == '0) && !side) begin
          side <= 1'b1;
          i    <= r0[NW-1:1];
        end
      end
      ST_RB_B: begin
        a  <= nm_rd;
        pv <= pend_rd;
      end
      ST_RB_C: i <= i >> 1;
      OP_OUT:  max_value <= best[OUT_W-1:0];
      default: ;
    endcase
  end

endmodule

// File: design/range_add_range_max_tree_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_add_range_max_tree_unit
// Lazy segment tree: range add of a signed value, range maximum query.
//
// The input channel (in_valid/in_ready) carries cmd, lo_index, hi_index and
// add_value. An add command (cmd 0) produces no result; a query (cmd 1)
// returns one max_value on the output channel (out_valid/out_ready), the
// range maximum floored at zero. Indices beyond the last leaf saturate.
// Commands are handled one at a time by a sequencer over node and pending-add
// memories with one read and one write port each: each push-down level
// hands a nonzero pending add on to both children and clears it, the range
// walk visits up to two nodes per level, and each rebuild level recomputes a
// node from its children. After reset both memories are cleared, one entry
// per cycle, while in_ready stays low. A query result sits in an output
// register; the next command is accepted while it waits, and only a later
// query waits for the receiver to take the transfer.
// ----------------------------------------------------------------------------
module range_add_range_max_tree_unit #(
  parameter int LEAVES = rarmt_pkg::LEAVES_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               cmd,
  input  logic [rarmt_pkg::IDX_W-1:0]        lo_index,
  input  logic [rarmt_pkg::IDX_W-1:0]        hi_index,
  input  logic signed [rarmt_pkg::VAL_W-1:0] add_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [rarmt_pkg::OUT_W-1:0]        max_value
);
  import rarmt_pkg::*;

  op_t     op;
  status_t st;

  // Sequencer.
  rarmt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .op        (op)
  );

  // Memories and working registers.
  rarmt_datapath #(
    .LEAVES (LEAVES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .cmd       (cmd),
    .lo_index  (lo_index),
    .hi_index  (hi_index),
    .add_value (add_value),
    .max_value (max_value),
    .st        (st)
  );

  // A command keeps the block busy in the cycle after its transfer.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  // The clearing pass holds off commands and results right after reset.
  assert property (@(posedge clk)
    rst |=> (!in_ready && !out_valid))
    else $error("block active during clearing pass");

  // A new result is only loaded in a cycle without an input transfer.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result raised right after a command transfer");

endmodule
